@@ rtl/core/aabb_pkg.sv @@
// Shared widths, stage payload types and helper functions for the box contact pipeline.
// Depends on nothing; every module of aabb_contact_normal refers to it by scoped names.
package aabb_pkg;

	// Coordinate width and the widths that follow from it.
	localparam int COORD_WIDTH = 24;
	localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
	localparam int OUT_WIDTH   = COORD_WIDTH + 2;
	localparam int DT_WIDTH    = 16;
	// Internal Q.9 positions, distances, and the velocity times time step product.
	localparam int INT_WIDTH   = COORD_WIDTH + 4;
	localparam int DIST_WIDTH  = INT_WIDTH + 1;
	localparam int PROD_WIDTH  = COORD_WIDTH + DT_WIDTH + 1;
	// The product is Q.24; dropping this many bits gives Q.9.
	localparam int PROD_SHIFT  = 15;
	localparam int DISP_WIDTH  = PROD_WIDTH - PROD_SHIFT;

	typedef enum logic [1:0] {
		SIDE_LEFT  = 2'd0,
		SIDE_RIGHT = 2'd1,
		SIDE_UP    = 2'd2,
		SIDE_DOWN  = 2'd3
	} side_t;

	// Stage one: grown target edges, centres and raw displacement products.
	typedef struct packed {
		logic signed [INT_WIDTH-1:0]  cx;
		logic signed [INT_WIDTH-1:0]  cy;
		logic signed [INT_WIDTH-1:0]  el;
		logic signed [INT_WIDTH-1:0]  er;
		logic signed [INT_WIDTH-1:0]  et;
		logic signed [INT_WIDTH-1:0]  eb;
		logic signed [PROD_WIDTH-1:0] prod_x;
		logic signed [PROD_WIDTH-1:0] prod_y;
	} s1_t;

	// Stage two: moved centre, edges, current centre and side distances.
	typedef struct packed {
		logic signed [INT_WIDTH-1:0]  cx;
		logic signed [INT_WIDTH-1:0]  cy;
		logic signed [INT_WIDTH-1:0]  nx;
		logic signed [INT_WIDTH-1:0]  ny;
		logic signed [INT_WIDTH-1:0]  el;
		logic signed [INT_WIDTH-1:0]  er;
		logic signed [INT_WIDTH-1:0]  et;
		logic signed [INT_WIDTH-1:0]  eb;
		logic signed [DIST_WIDTH-1:0] dl;
		logic signed [DIST_WIDTH-1:0] dr;
		logic signed [DIST_WIDTH-1:0] du;
		logic signed [DIST_WIDTH-1:0] dd;
	} s2_t;

	function automatic logic signed [INT_WIDTH-1:0] sext_coord(
		input logic [COORD_WIDTH-1:0] v
	);
		return {{(INT_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
	endfunction

	function automatic logic signed [INT_WIDTH-1:0] zext_size(
		input logic [SIZE_WIDTH-1:0] v
	);
		return {{(INT_WIDTH-SIZE_WIDTH){1'b0}}, v};
	endfunction

	function automatic logic signed [DIST_WIDTH-1:0] sext_dist(
		input logic signed [INT_WIDTH-1:0] v
	);
		return {v[INT_WIDTH-1], v};
	endfunction

	function automatic logic signed [DIST_WIDTH-1:0] abs_dist(
		input logic signed [DIST_WIDTH-1:0] v
	);
		return v[DIST_WIDTH-1] ? -v : v;
	endfunction

endpackage

@@ rtl/core/aabb_expand.sv @@
// First pipeline stage: Minkowski growth of the target, box centres and displacement products.
// Depends on aabb_pkg.
module aabb_expand (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]     mover_pos_x,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]     mover_pos_y,
	input  logic [aabb_pkg::SIZE_WIDTH-1:0]      mover_width,
	input  logic [aabb_pkg::SIZE_WIDTH-1:0]      mover_height,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]     velocity_x,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]     velocity_y,
	input  logic [aabb_pkg::DT_WIDTH-1:0]        time_step,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]     target_pos_x,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]     target_pos_y,
	input  logic [aabb_pkg::SIZE_WIDTH-1:0]      target_width,
	input  logic [aabb_pkg::SIZE_WIDTH-1:0]      target_height,
	output logic                                 vld_s1,
	output aabb_pkg::s1_t                        stg_s1
);

	aabb_pkg::s1_t nxt;
	logic signed [aabb_pkg::DT_WIDTH:0] dt_ext;

	always_comb begin
		dt_ext     = $signed({1'b0, time_step});
		nxt.cx     = (aabb_pkg::sext_coord(mover_pos_x) <<< 1) + aabb_pkg::zext_size(mover_width);
		nxt.cy     = (aabb_pkg::sext_coord(mover_pos_y) <<< 1)
			+ aabb_pkg::zext_size(mover_height);
		nxt.el     = (aabb_pkg::sext_coord(target_pos_x) <<< 1)
			- aabb_pkg::zext_size(mover_width);
		nxt.er     = (aabb_pkg::sext_coord(target_pos_x) <<< 1)
			+ (aabb_pkg::zext_size(target_width) <<< 1) + aabb_pkg::zext_size(mover_width);
		nxt.et     = (aabb_pkg::sext_coord(target_pos_y) <<< 1)
			- aabb_pkg::zext_size(mover_height);
		nxt.eb     = (aabb_pkg::sext_coord(target_pos_y) <<< 1)
			+ (aabb_pkg::zext_size(target_height) <<< 1) + aabb_pkg::zext_size(mover_height);
		nxt.prod_x = $signed(velocity_x) * dt_ext;
		nxt.prod_y = $signed(velocity_y) * dt_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			stg_s1 <= nxt;
		end
	end

endmodule

@@ rtl/core/aabb_dist.sv @@
// Second pipeline stage: moved centre and the distances from the current centre to each side.
// Depends on aabb_pkg.
module aabb_dist (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_s1,
	input  aabb_pkg::s1_t stg_s1,
	output logic          vld_s2,
	output aabb_pkg::s2_t stg_s2
);

	aabb_pkg::s2_t nxt;
	logic signed [aabb_pkg::DISP_WIDTH-1:0] disp_x;
	logic signed [aabb_pkg::DISP_WIDTH-1:0] disp_y;

	always_comb begin
		// Dropping the low bits of a two's complement value rounds toward minus infinity.
		disp_x = stg_s1.prod_x[aabb_pkg::PROD_WIDTH-1:aabb_pkg::PROD_SHIFT];
		disp_y = stg_s1.prod_y[aabb_pkg::PROD_WIDTH-1:aabb_pkg::PROD_SHIFT];
		nxt.cx = stg_s1.cx;
		nxt.cy = stg_s1.cy;
		nxt.el = stg_s1.el;
		nxt.er = stg_s1.er;
		nxt.et = stg_s1.et;
		nxt.eb = stg_s1.eb;
		nxt.nx = stg_s1.cx
			+ {{(aabb_pkg::INT_WIDTH-aabb_pkg::DISP_WIDTH){disp_x[aabb_pkg::DISP_WIDTH-1]}}, disp_x};
		nxt.ny = stg_s1.cy
			+ {{(aabb_pkg::INT_WIDTH-aabb_pkg::DISP_WIDTH){disp_y[aabb_pkg::DISP_WIDTH-1]}}, disp_y};
		nxt.dl = aabb_pkg::sext_dist(stg_s1.cx) - aabb_pkg::sext_dist(stg_s1.el);
		nxt.dr = aabb_pkg::abs_dist(aabb_pkg::sext_dist(stg_s1.cx)
			- aabb_pkg::sext_dist(stg_s1.er));
		nxt.du = aabb_pkg::abs_dist(aabb_pkg::sext_dist(stg_s1.cy)
			- aabb_pkg::sext_dist(stg_s1.et));
		nxt.dd = aabb_pkg::abs_dist(aabb_pkg::sext_dist(stg_s1.cy)
			- aabb_pkg::sext_dist(stg_s1.eb));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			stg_s2 <= nxt;
		end
	end

endmodule

@@ rtl/core/aabb_pick.sv @@
// Third and fourth pipeline stages: hit test, side choice, then saturation into the result ports.
// Depends on aabb_pkg.
module aabb_pick (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  vld_s2,
	input  aabb_pkg::s2_t                         stg_s2,
	output logic                                  done,
	output logic                                  hit,
	output logic [1:0]                            normal_side,
	output logic signed [aabb_pkg::OUT_WIDTH-1:0] contact_x,
	output logic signed [aabb_pkg::OUT_WIDTH-1:0] contact_y
);

	localparam logic signed [aabb_pkg::INT_WIDTH-1:0] OUT_HI =
		{{(aabb_pkg::INT_WIDTH-aabb_pkg::OUT_WIDTH+1){1'b0}}, {(aabb_pkg::OUT_WIDTH-1){1'b1}}};
	localparam logic signed [aabb_pkg::INT_WIDTH-1:0] OUT_LO = ~OUT_HI;

	logic                                  in_box;
	logic signed [aabb_pkg::DIST_WIDTH-1:0] min_h;
	logic signed [aabb_pkg::DIST_WIDTH-1:0] min_v;
	aabb_pkg::side_t                       side_c;
	logic signed [aabb_pkg::INT_WIDTH-1:0] px_c;
	logic signed [aabb_pkg::INT_WIDTH-1:0] py_c;

	logic                                  vld_s3;
	logic                                  hit_s3;
	aabb_pkg::side_t                       side_s3;
	logic signed [aabb_pkg::INT_WIDTH-1:0] px_s3;
	logic signed [aabb_pkg::INT_WIDTH-1:0] py_s3;

	logic signed [aabb_pkg::INT_WIDTH-1:0] px_sat;
	logic signed [aabb_pkg::INT_WIDTH-1:0] py_sat;

	always_comb begin
		in_box = (stg_s2.nx > stg_s2.el) && (stg_s2.nx < stg_s2.er)
			&& (stg_s2.ny > stg_s2.et) && (stg_s2.ny < stg_s2.eb);
		min_h  = (stg_s2.dl < stg_s2.dr) ? stg_s2.dl : stg_s2.dr;
		min_v  = (stg_s2.du < stg_s2.dd) ? stg_s2.du : stg_s2.dd;
		// Ties between the axes go to the vertical sides, ties within an axis go right or down.
		if (min_h < min_v) begin
			side_c = (stg_s2.dl < stg_s2.dr) ? aabb_pkg::SIDE_LEFT : aabb_pkg::SIDE_RIGHT;
			px_c   = (stg_s2.dl < stg_s2.dr) ? stg_s2.el : stg_s2.er;
			py_c   = stg_s2.cy;
		end else begin
			side_c = (stg_s2.du < stg_s2.dd) ? aabb_pkg::SIDE_UP : aabb_pkg::SIDE_DOWN;
			px_c   = stg_s2.cx;
			py_c   = (stg_s2.du < stg_s2.dd) ? stg_s2.et : stg_s2.eb;
		end
	end

	always_comb begin
		px_sat = (px_s3 > OUT_HI) ? OUT_HI : ((px_s3 < OUT_LO) ? OUT_LO : px_s3);
		py_sat = (py_s3 > OUT_HI) ? OUT_HI : ((py_s3 < OUT_LO) ? OUT_LO : py_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			done   <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			hit_s3  <= in_box;
			side_s3 <= in_box ? side_c : aabb_pkg::SIDE_LEFT;
			px_s3   <= in_box ? px_c : '0;
			py_s3   <= in_box ? py_c : '0;
		end
		if (vld_s3) begin
			hit         <= hit_s3;
			normal_side <= side_s3;
			contact_x   <= px_sat[aabb_pkg::OUT_WIDTH-1:0];
			contact_y   <= py_sat[aabb_pkg::OUT_WIDTH-1:0];
		end
	end

endmodule

@@ rtl/core/aabb_contact_normal.sv @@
// A transaction accepted at a rising edge has its result strobed by done after it passes
// the four register stages: the expansion and multiply stage, the distance stage,
// the side choice stage and the output register. Throughput: one transaction per cycle,
// since busy is always low and the result side cannot stall. Reset (arst_n low) clears
// only the valid bits of the stages; transactions in flight are dropped.
// Depends on aabb_pkg, aabb_expand, aabb_dist and aabb_pick.
module aabb_contact_normal (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]      mover_pos_x,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]      mover_pos_y,
	input  logic [aabb_pkg::SIZE_WIDTH-1:0]       mover_width,
	input  logic [aabb_pkg::SIZE_WIDTH-1:0]       mover_height,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]      velocity_x,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]      velocity_y,
	input  logic [aabb_pkg::DT_WIDTH-1:0]         time_step,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]      target_pos_x,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]      target_pos_y,
	input  logic [aabb_pkg::SIZE_WIDTH-1:0]       target_width,
	input  logic [aabb_pkg::SIZE_WIDTH-1:0]       target_height,
	output logic                                  done,
	output logic                                  hit,
	output logic [1:0]                            normal_side,
	output logic signed [aabb_pkg::OUT_WIDTH-1:0] contact_x,
	output logic signed [aabb_pkg::OUT_WIDTH-1:0] contact_y
);

	// Every stage moves forward on every cycle, so a new transaction is always welcome.
	assign busy = 1'b0;

	logic          vld_s1;
	aabb_pkg::s1_t stg_s1;
	logic          vld_s2;
	aabb_pkg::s2_t stg_s2;

	// Stage one grows the target by the mover's size, forms both centres in Q.9
	// (twice the edge plus the size, so no half units are lost) and multiplies
	// velocity by the time step on each axis.
	aabb_expand u_expand (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (start & ~busy),
		.mover_pos_x   (mover_pos_x),
		.mover_pos_y   (mover_pos_y),
		.mover_width   (mover_width),
		.mover_height  (mover_height),
		.velocity_x    (velocity_x),
		.velocity_y    (velocity_y),
		.time_step     (time_step),
		.target_pos_x  (target_pos_x),
		.target_pos_y  (target_pos_y),
		.target_width  (target_width),
		.target_height (target_height),
		.vld_s1        (vld_s1),
		.stg_s1        (stg_s1)
	);

	// Stage two floors the products to Q.9, moves the centre, and measures the
	// current centre against each side of the grown target. The left distance
	// keeps its sign; the other three are magnitudes.
	aabb_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (vld_s1),
		.stg_s1 (stg_s1),
		.vld_s2 (vld_s2),
		.stg_s2 (stg_s2)
	);

	// Stages three and four test the moved centre strictly inside the grown target,
	// pick the nearest side, and saturate the contact point into the output range.
	// A miss reports side zero and a zero contact point.
	aabb_pick u_pick (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld_s2      (vld_s2),
		.stg_s2      (stg_s2),
		.done        (done),
		.hit         (hit),
		.normal_side (normal_side),
		.contact_x   (contact_x),
		.contact_y   (contact_y)
	);

	// Every accepted transaction comes out as a done strobe.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted transaction produced no result after four cycles");

	// No result appears without a matching earlier transaction.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result strobe without a matching transaction");

	// A miss carries an all-zero contact.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (normal_side == aabb_pkg::SIDE_LEFT && contact_x == '0
			&& contact_y == '0))
		else $error("miss result with nonzero contact fields");

endmodule

@@ bench/contact_checker.sv @@
// Checker for aabb_contact_normal: watches the command and result channels, predicts each
// contact result from the accepted transaction and compares it field by field.
// Depends on aabb_pkg for the widths and the side_t encoding.
module contact_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  busy,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]      mover_pos_x,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]      mover_pos_y,
	input  logic [aabb_pkg::SIZE_WIDTH-1:0]       mover_width,
	input  logic [aabb_pkg::SIZE_WIDTH-1:0]       mover_height,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]      velocity_x,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]      velocity_y,
	input  logic [aabb_pkg::DT_WIDTH-1:0]         time_step,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]      target_pos_x,
	input  logic [aabb_pkg::COORD_WIDTH-1:0]      target_pos_y,
	input  logic [aabb_pkg::SIZE_WIDTH-1:0]       target_width,
	input  logic [aabb_pkg::SIZE_WIDTH-1:0]       target_height,
	input  logic                                  done,
	input  logic                                  hit,
	input  logic [1:0]                            normal_side,
	input  logic signed [aabb_pkg::OUT_WIDTH-1:0] contact_x,
	input  logic signed [aabb_pkg::OUT_WIDTH-1:0] contact_y,
	output int                                    failures,
	output int                                    pending,
	output int                                    checked,
	output int                                    hits,
	output int                                    saturated
);

	localparam int COORD_WIDTH = aabb_pkg::COORD_WIDTH;
	localparam int SIZE_WIDTH  = aabb_pkg::SIZE_WIDTH;
	localparam int DT_WIDTH    = aabb_pkg::DT_WIDTH;
	localparam int OUT_WIDTH   = aabb_pkg::OUT_WIDTH;

	typedef struct packed {
		logic                        hit;
		aabb_pkg::side_t             side;
		logic signed [OUT_WIDTH-1:0] x;
		logic signed [OUT_WIDTH-1:0] y;
	} contact_t;

	localparam longint Q9_MAX = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
	localparam longint Q9_MIN = -(longint'(1) <<< (OUT_WIDTH - 1));
	localparam logic signed [OUT_WIDTH-1:0] Q9_TOP = OUT_WIDTH'(Q9_MAX);

	contact_t expected_contacts[$];
	int fail_count = 0;
	int checked_count = 0;
	int hit_count = 0;
	int sat_count = 0;

	function automatic logic signed [OUT_WIDTH-1:0] clamp_q9(input longint v);
		if (v > Q9_MAX) return Q9_TOP;
		if (v < Q9_MIN) return OUT_WIDTH'(Q9_MIN);
		return OUT_WIDTH'(v);
	endfunction

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic contact_t predict_contact(
		input logic signed [COORD_WIDTH-1:0] mpx, mpy,
		input logic        [SIZE_WIDTH-1:0]  msw, msh,
		input logic signed [COORD_WIDTH-1:0] vlx, vly,
		input logic        [DT_WIDTH-1:0]    tstep,
		input logic signed [COORD_WIDTH-1:0] tpx, tpy,
		input logic        [SIZE_WIDTH-1:0]  tsw, tsh
	);
		longint mx, my, mw, mh, vx, vy, dt, tx, ty, tw, th;
		longint cx, cy, el, er, et, eb, nx, ny, dl, dr, du, dd, px, py;
		contact_t c;
		mx = mpx; my = mpy; mw = msw; mh = msh;
		vx = vlx; vy = vly; dt = tstep;
		tx = tpx; ty = tpy; tw = tsw; th = tsh;
		// Everything below is in Q.9, where a centre is exact as 2*edge + size.
		cx = 2 * mx + mw;
		cy = 2 * my + mh;
		el = 2 * tx - mw;
		er = 2 * tx + 2 * tw + mw;
		et = 2 * ty - mh;
		eb = 2 * ty + 2 * th + mh;
		// The displacement is Q.24; an arithmetic shift floors it into Q.9.
		nx = cx + ((vx * dt) >>> 15);
		ny = cy + ((vy * dt) >>> 15);
		c.hit = 1'b0;
		c.side = aabb_pkg::SIDE_LEFT;
		c.x = '0;
		c.y = '0;
		if (!(nx > el && nx < er && ny > et && ny < eb)) return c;
		// The side is picked from the current centre. The left distance keeps its sign.
		dl = cx - el;
		dr = magnitude(cx - er);
		du = magnitude(cy - et);
		dd = magnitude(cy - eb);
		if (((dl < dr) ? dl : dr) < ((du < dd) ? du : dd)) begin
			if (dl < dr) begin
				c.side = aabb_pkg::SIDE_LEFT;
				px = el;
			end else begin
				c.side = aabb_pkg::SIDE_RIGHT;
				px = er;
			end
			py = cy;
		end else begin
			if (du < dd) begin
				c.side = aabb_pkg::SIDE_UP;
				py = et;
			end else begin
				c.side = aabb_pkg::SIDE_DOWN;
				py = eb;
			end
			px = cx;
		end
		c.hit = 1'b1;
		c.x = clamp_q9(px);
		c.y = clamp_q9(py);
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		contact_t e;
		if (!arst_n) begin
			expected_contacts.delete();
			pending <= 0;
		end else begin
			// Results first: with a registered pipeline a result never belongs to the
			// transaction accepted at the same edge.
			if (done) begin
				if (expected_contacts.size() == 0) begin
					$error("contact result strobed with no transaction outstanding");
					fail_count++;
				end else begin
					e = expected_contacts.pop_front();
					checked_count++;
					if (hit !== e.hit) begin
						$error("hit: expected %0d, got %0d", e.hit, hit);
						fail_count++;
					end
					if (normal_side !== e.side) begin
						$error("normal_side: expected %0d, got %0d", e.side, normal_side);
						fail_count++;
					end
					if (contact_x !== e.x) begin
						$error("contact_x: expected %0d, got %0d", e.x, contact_x);
						fail_count++;
					end
					if (contact_y !== e.y) begin
						$error("contact_y: expected %0d, got %0d", e.y, contact_y);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				e = predict_contact(mover_pos_x, mover_pos_y, mover_width, mover_height,
					velocity_x, velocity_y, time_step, target_pos_x, target_pos_y,
					target_width, target_height);
				if (e.hit) hit_count++;
				if (e.hit && (e.x == Q9_TOP || e.y == Q9_TOP)) sat_count++;
				expected_contacts.push_back(e);
			end
			pending <= expected_contacts.size();
		end
		failures <= fail_count;
		checked <= checked_count;
		hits <= hit_count;
		saturated <= sat_count;
	end

endmodule

@@ bench/tb.sv @@
// Top of the aabb_contact_normal bench: clock, reset, directed and random box pairs, sender
// idling, a stall watchdog and the final verdict. Checking lives in contact_checker.
// Depends on aabb_pkg, aabb_contact_normal and contact_checker.
module tb;

	localparam int COORD_WIDTH = aabb_pkg::COORD_WIDTH;
	localparam int SIZE_WIDTH  = aabb_pkg::SIZE_WIDTH;
	localparam int DT_WIDTH    = aabb_pkg::DT_WIDTH;
	localparam int OUT_WIDTH   = aabb_pkg::OUT_WIDTH;

	// A run with no transaction moving in either direction for this many cycles is hung.
	// The longest legal quiet stretch is a sender gap (capped at MAX_GAP) plus the pipeline.
	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_ITEMS = 360;
	localparam int MAX_GAP = 200;
	localparam int U = 256;
	localparam int MAXC = 8388607;
	localparam int MINC = -8388608;
	localparam int MAXS = 8388607;
	localparam int MAXDT = 65535;

	// One command as the sender sees it, each field at its port width.
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] mover_pos_x;
		logic signed [COORD_WIDTH-1:0] mover_pos_y;
		logic        [SIZE_WIDTH-1:0]  mover_width;
		logic        [SIZE_WIDTH-1:0]  mover_height;
		logic signed [COORD_WIDTH-1:0] velocity_x;
		logic signed [COORD_WIDTH-1:0] velocity_y;
		logic        [DT_WIDTH-1:0]    time_step;
		logic signed [COORD_WIDTH-1:0] target_pos_x;
		logic signed [COORD_WIDTH-1:0] target_pos_y;
		logic        [SIZE_WIDTH-1:0]  target_width;
		logic        [SIZE_WIDTH-1:0]  target_height;
	} box_query_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [COORD_WIDTH-1:0]      mover_pos_x;
	logic [COORD_WIDTH-1:0]      mover_pos_y;
	logic [SIZE_WIDTH-1:0]       mover_width;
	logic [SIZE_WIDTH-1:0]       mover_height;
	logic [COORD_WIDTH-1:0]      velocity_x;
	logic [COORD_WIDTH-1:0]      velocity_y;
	logic [DT_WIDTH-1:0]         time_step;
	logic [COORD_WIDTH-1:0]      target_pos_x;
	logic [COORD_WIDTH-1:0]      target_pos_y;
	logic [SIZE_WIDTH-1:0]       target_width;
	logic [SIZE_WIDTH-1:0]       target_height;
	logic                        done;
	logic                        hit;
	logic [1:0]                  normal_side;
	logic signed [OUT_WIDTH-1:0] contact_x;
	logic signed [OUT_WIDTH-1:0] contact_y;

	int failures;
	int pending;
	int checked;
	int hits;
	int saturated;
	int idle_pct = 0;
	int sent_count = 0;
	int stall_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	aabb_contact_normal u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mover_pos_x(mover_pos_x), .mover_pos_y(mover_pos_y),
		.mover_width(mover_width), .mover_height(mover_height),
		.velocity_x(velocity_x), .velocity_y(velocity_y), .time_step(time_step),
		.target_pos_x(target_pos_x), .target_pos_y(target_pos_y),
		.target_width(target_width), .target_height(target_height),
		.done(done), .hit(hit), .normal_side(normal_side),
		.contact_x(contact_x), .contact_y(contact_y)
	);

	contact_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mover_pos_x(mover_pos_x), .mover_pos_y(mover_pos_y),
		.mover_width(mover_width), .mover_height(mover_height),
		.velocity_x(velocity_x), .velocity_y(velocity_y), .time_step(time_step),
		.target_pos_x(target_pos_x), .target_pos_y(target_pos_y),
		.target_width(target_width), .target_height(target_height),
		.done(done), .hit(hit), .normal_side(normal_side),
		.contact_x(contact_x), .contact_y(contact_y),
		.failures(failures), .pending(pending), .checked(checked),
		.hits(hits), .saturated(saturated)
	);

	// Watchdog: any accepted command or strobed result resets the count. If the block
	// swallows transactions or never answers, the count runs out and the run fails.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("aabb_contact_normal regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Packs plain integers into a command; each value is cut to its field width, so
	// negative numbers land as two's complement and oversized ones simply wrap.
	function automatic box_query_t make_query(input int mx, my, mw, mh, vx, vy, dt,
			tx, ty, tw, th);
		box_query_t q;
		q.mover_pos_x = COORD_WIDTH'(mx);
		q.mover_pos_y = COORD_WIDTH'(my);
		q.mover_width = SIZE_WIDTH'(mw);
		q.mover_height = SIZE_WIDTH'(mh);
		q.velocity_x = COORD_WIDTH'(vx);
		q.velocity_y = COORD_WIDTH'(vy);
		q.time_step = DT_WIDTH'(dt);
		q.target_pos_x = COORD_WIDTH'(tx);
		q.target_pos_y = COORD_WIDTH'(ty);
		q.target_width = SIZE_WIDTH'(tw);
		q.target_height = SIZE_WIDTH'(th);
		return q;
	endfunction

	// Random pairs come in three flavors. A fifth are raw noise over the whole field
	// range, which is what toggles every input bit. A smaller share are tiny boxes
	// near the origin, where exact edge and tie cases turn up by chance. The bulk are
	// overlapping pairs at one random scale, so the hit path and the side choice see
	// most of the traffic; some of these are centred on purpose to force ties.
	function automatic box_query_t random_query();
		int pick, k, tx, ty, tw, th, mw, mh, mx, my, vx, vy;
		pick = $urandom_range(99);
		if (pick < 20) begin
			return make_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom);
		end
		if (pick < 35) begin
			return make_query(int'($urandom) >>> 22, int'($urandom) >>> 22,
				$urandom_range(1023), $urandom_range(1023),
				int'($urandom) >>> 20, int'($urandom) >>> 20, $urandom,
				int'($urandom) >>> 22, int'($urandom) >>> 22,
				$urandom_range(1023), $urandom_range(1023));
		end
		k = $urandom_range(2, 22);
		tw = $urandom_range((1 << k) - 1);
		th = $urandom_range((1 << k) - 1);
		mw = $urandom_range((1 << k) - 1);
		mh = $urandom_range((1 << k) - 1);
		tx = int'($urandom) >>> 9;
		ty = int'($urandom) >>> 9;
		mx = tx - mw + int'($urandom_range(tw + mw));
		my = ty - mh + int'($urandom_range(th + mh));
		// A mover centred on the target makes the left and right distances equal.
		if ($urandom_range(7) == 0) begin
			tw = tw & ~1;
			mw = mw & ~1;
			mx = tx + (tw - mw) / 2;
		end
		if ($urandom_range(7) == 0) begin
			th = th & ~1;
			mh = mh & ~1;
			my = ty + (th - mh) / 2;
		end
		// Velocity on the order of the box scale, so a time step moves the centre
		// across, along or out of the grown target about equally often.
		vx = ($urandom_range(2) == 0) ? 0 : int'($urandom) >>> (30 - k);
		vy = ($urandom_range(2) == 0) ? 0 : int'($urandom) >>> (30 - k);
		return make_query(mx, my, mw, mh, vx, vy, $urandom, tx, ty, tw, th);
	endfunction

	// Presents one command and returns once it has been accepted. The idle gap before
	// it is geometric with the current idle percentage, so short and long gaps both
	// occur and land at every pipeline stage. start stays high between back to back
	// transactions and is written once per time step.
	task automatic send_query(input box_query_t q);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mover_pos_x <= q.mover_pos_x;
		mover_pos_y <= q.mover_pos_y;
		mover_width <= q.mover_width;
		mover_height <= q.mover_height;
		velocity_x <= q.velocity_x;
		velocity_y <= q.velocity_y;
		time_step <= q.time_step;
		target_pos_x <= q.target_pos_x;
		target_pos_y <= q.target_pos_y;
		target_width <= q.target_width;
		target_height <= q.target_height;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent_count++;
	endtask

	// Holds the sender off until the checker has nothing outstanding, which empties the
	// pipeline completely before traffic resumes.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int phase_idle [3];
		int directed_count;
		phase_idle = '{36, 74, 0};
		arst_n = 1'b0;
		start = 1'b0;
		mover_pos_x = '0;
		mover_pos_y = '0;
		mover_width = '0;
		mover_height = '0;
		velocity_x = '0;
		velocity_y = '0;
		time_step = '0;
		target_pos_x = '0;
		target_pos_y = '0;
		target_width = '0;
		target_height = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs. Most use a 10 by 10 unit target at the origin and a 2 by 2 unit
		// mover, which grows the target to the Q.9 span -512 .. 5632 on both axes.
		idle_pct = phase_idle[0];
		// Field extremes: all zero, all maximum, all minimum, all bits set.
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(make_query(MAXC, MAXC, MAXS, MAXS, MAXC, MAXC, MAXDT,
			MAXC, MAXC, MAXS, MAXS));
		send_query(make_query(MINC, MINC, 0, 0, MINC, MINC, 0, MINC, MINC, 0, 0));
		send_query(make_query(-1, -1, MAXS, MAXS, -1, -1, MAXDT, -1, -1, MAXS, MAXS));
		// One clear winner for each of the four sides.
		send_query(make_query(0, 4*U, 2*U, 2*U, 0, 0, 0, 0, 0, 10*U, 10*U));
		send_query(make_query(8*U, 4*U, 2*U, 2*U, 0, 0, 0, 0, 0, 10*U, 10*U));
		send_query(make_query(4*U, 0, 2*U, 2*U, 0, 0, 0, 0, 0, 10*U, 10*U));
		send_query(make_query(4*U, 8*U, 2*U, 2*U, 0, 0, 0, 0, 0, 10*U, 10*U));
		// Ties: all four distances equal goes vertical and then down; a left-right tie
		// on a tall target goes right; an up-down tie on a wide target goes down.
		send_query(make_query(4*U, 4*U, 2*U, 2*U, 0, 0, 0, 0, 0, 10*U, 10*U));
		send_query(make_query(4*U, 20*U, 2*U, 2*U, 0, 0, 0, 0, 0, 10*U, 40*U));
		send_query(make_query(20*U, 4*U, 2*U, 2*U, 0, 0, 0, 0, 0, 40*U, 10*U));
		// Centre exactly on the grown left edge is not strictly inside.
		send_query(make_query(-2*U, 4*U, 2*U, 2*U, 0, 0, 0, 0, 0, 10*U, 10*U));
		// Mover starts outside on the left and moves in, so the left distance is negative.
		send_query(make_query(-3*U, 4*U, 2*U, 2*U, 100*U, 0, 1000, 0, 0, 10*U, 10*U));
		// Displacement rounding toward minus infinity: -32769/32768 floors to -2 and puts
		// the centre on the edge (miss), while -32768/32768 is exactly -1 (hit).
		send_query(make_query(-511, 4*U, 2*U, 2*U, -1, 0, 32769, 0, 0, 10*U, 10*U));
		send_query(make_query(-511, 4*U, 2*U, 2*U, -1, 0, 32768, 0, 0, 10*U, 10*U));
		// Right and bottom edges of a grown target beyond the output range saturate.
		send_query(make_query(MAXC, 0, MAXS, MAXS, 0, 0, 0, MAXC, 0, 'h600000, MAXS));
		send_query(make_query(0, MAXC, MAXS, MAXS, 0, 0, 0, 0, MAXC, MAXS, 'h600000));
		// Full scale velocity over a full time step carries the centre far out.
		send_query(make_query(0, 0, 2*U, 2*U, MINC, MAXC, MAXDT, 0, 0, 10*U, 10*U));
		send_query(make_query(4*U, 4*U, 2*U, 2*U, MAXC, 0, MAXDT, 0, 0, 10*U, 10*U));
		// Degenerate boxes: zero-size mover against a one-LSB target.
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
		directed_count = sent_count;
		drain_results();

		// Random phases: sender idle 36 percent, then 74 percent, then never.
		for (int p = 0; p < 3; p++) begin
			idle_pct = phase_idle[p];
			repeat (PHASE_ITEMS) send_query(random_query());
			drain_results();
		end

		// The pipeline is four stages deep; a few more edges catch any stray strobe.
		repeat (8) @(posedge clk);
		$display("Covered %0d transactions (%0d directed), %0d results checked, %0d hits,",
			sent_count, directed_count, checked, hits);
		$display("%0d saturated contacts; sender idle at 36, 74 and 0 percent in turn.",
			saturated);
		if (failures == 0) begin
			$display("aabb_contact_normal regression: pass");
		end else begin
			$display("aabb_contact_normal regression: fail");
		end
		$finish;
	end

endmodule
